// ===== hw/rtl/jts_pkg.sv =====
// jts_pkg: token and byte payload types, kind codes and byte tables for the
// JSON token serializer. No dependencies.

package jts_pkg;

  localparam int unsigned NumW      = 64;
  localparam int unsigned BcdDigits = 20;
  localparam int unsigned BcdW      = 4 * BcdDigits;

  localparam logic [2:0] KIND_RAW   = 3'd0;
  localparam logic [2:0] KIND_OPEN  = 3'd1;
  localparam logic [2:0] KIND_STR   = 3'd2;
  localparam logic [2:0] KIND_CLOSE = 3'd3;
  localparam logic [2:0] KIND_INT   = 3'd4;
  localparam logic [2:0] KIND_BOOL  = 3'd5;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CtrlLimit = 8'd32;

  typedef struct packed {
    logic [2:0]            kind;
    logic [7:0]            byte_value;
    logic signed [NumW-1:0] number;
    logic                  truth;
    logic                  comma_before;
  } tok_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } tok_out_t;

  localparam logic [7:0] WORD_TRUE  [4] = '{8'h74, 8'h72, 8'h75, 8'h65};
  localparam logic [7:0] WORD_FALSE [5] = '{8'h66, 8'h61, 8'h6c, 8'h73, 8'h65};

  // two-character escape letter, 0 when the byte has none
  function automatic logic [7:0] esc_char(input logic [7:0] c);
    logic [7:0] e;
    e = 8'h00;
    unique case (c)
      CH_BSL:   e = CH_BSL;
      CH_QUOTE: e = CH_QUOTE;
      8'd8:     e = 8'h62;
      8'd12:    e = 8'h66;
      8'd10:    e = 8'h6e;
      8'd13:    e = 8'h72;
      8'd9:     e = 8'h74;
      default:  e = 8'h00;
    endcase
    return e;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (8'h57 + {4'd0, n});
  endfunction

  // byte count of a non-integer token, comma excluded
  function automatic logic [2:0] seq_len(input logic [2:0] kind, input logic [7:0] b,
                                         input logic truth);
    logic [2:0] n;
    n = 3'd1;
    if (kind == KIND_STR) begin
      if (esc_char(b) != 8'h00) n = 3'd2;
      else if (b < CtrlLimit)   n = 3'd6;
    end else if (kind == KIND_BOOL) begin
      n = truth ? 3'd4 : 3'd5;
    end
    return n;
  endfunction

  function automatic logic [7:0] seq_byte(input logic [2:0] kind, input logic [7:0] b,
                                          input logic truth, input logic [2:0] idx);
    logic [7:0] r;
    logic [7:0] e;
    e = esc_char(b);
    r = b;
    if (kind == KIND_OPEN || kind == KIND_CLOSE) begin
      r = CH_QUOTE;
    end else if (kind == KIND_BOOL) begin
      r = truth ? WORD_TRUE[idx[1:0]] : WORD_FALSE[(idx > 3'd4) ? 3'd4 : idx];
    end else if (kind == KIND_STR) begin
      if (e != 8'h00) begin
        r = (idx == 3'd0) ? CH_BSL : e;
      end else if (b < CtrlLimit) begin
        unique case (idx)
          3'd0:    r = CH_BSL;
          3'd1:    r = CH_U;
          3'd4:    r = hex_char(b[7:4]);
          3'd5:    r = hex_char(b[3:0]);
          default: r = CH_ZERO;
        endcase
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/json_token_serializer.sv =====
// json_token_serializer: one JSON token in, its text out one byte at a time.
// Depends on jts_pkg (payload types, kind codes, escape and word tables).
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries one token request
//   (kind, byte_value, number, truth, comma_before). Output channel
//   out_valid_o / out_ready_i carries bytes; last marks the final byte of a
//   token. Kinds 6 and 7 are taken and produce nothing.
//   One token is in work at a time; in_ready_o is high while the sequencer
//   is idle, also while the final byte still sits in the output register.
//   Non-integer tokens: one byte per cycle while the receiver does not stall;
//   after acceptance the state register is set, then the first byte is
//   loaded into the output register; 1 to 6 bytes (comma included).
//   Integers: the magnitude is converted to BCD by a shift-and-add-3
//   register, one bit per cycle; then leading zero digits are dropped one
//   per cycle (up to 19 digits); then comma, minus and digits follow at one
//   byte per cycle while the receiver does not stall.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle and
//   empties the output register.
//   When the receiver stalls, the output register holds its byte and the
//   sequencer waits; nothing is dropped.

module json_token_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  jts_pkg::tok_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jts_pkg::tok_out_t out_data_o
);
  import jts_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COMMA = 3'd1;
  localparam logic [2:0] S_SEQ   = 3'd2;
  localparam logic [2:0] S_CONV  = 3'd3;
  localparam logic [2:0] S_SKIP  = 3'd4;
  localparam logic [2:0] S_MINUS = 3'd5;
  localparam logic [2:0] S_DIGIT = 3'd6;

  localparam logic [5:0] ConvLast  = 6'(NumW - 1);
  localparam logic [4:0] DigitLast = 5'(BcdDigits - 1);

  logic [2:0]      state_q, state_d;
  logic [2:0]      kind_q;
  logic [7:0]      byte_q;
  logic            truth_q, comma_q, neg_q;
  logic [NumW-1:0] mag_q, mag_d;
  logic [BcdW-1:0] bcd_q, bcd_d, bcd_adj;
  logic [5:0]      cnt_q, cnt_d;
  logic [4:0]      dcnt_q, dcnt_d;
  logic [2:0]      idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  tok_out_t        out_q, out_d;

  logic       accept, can_load;
  logic [2:0] len;
  logic [3:0] top_digit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign can_load    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign len         = seq_len(kind_q, byte_q, truth_q);
  assign top_digit   = bcd_q[BcdW-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                    : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    dcnt_d      = dcnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d = 3'd0;
          if (in_data_i.kind == KIND_INT) begin
            mag_d   = in_data_i.number[NumW-1] ? (NumW'(0) - NumW'(in_data_i.number))
                                               : NumW'(in_data_i.number);
            bcd_d   = '0;
            cnt_d   = '0;
            dcnt_d  = '0;
            state_d = S_CONV;
          end else if (in_data_i.kind == KIND_OPEN || in_data_i.kind == KIND_BOOL) begin
            state_d = in_data_i.comma_before ? S_COMMA : S_SEQ;
          end else if (in_data_i.kind == KIND_RAW || in_data_i.kind == KIND_STR ||
                       in_data_i.kind == KIND_CLOSE) begin
            state_d = S_SEQ;
          end
        end
      end
      S_CONV: begin
        bcd_d = {bcd_adj[BcdW-2:0], mag_q[NumW-1]};
        mag_d = {mag_q[NumW-2:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == ConvLast) state_d = S_SKIP;
      end
      S_SKIP: begin
        if (top_digit == 4'd0 && dcnt_q != DigitLast) begin
          bcd_d  = {bcd_q[BcdW-5:0], 4'd0};
          dcnt_d = dcnt_q + 5'd1;
        end else if (comma_q) begin
          state_d = S_COMMA;
        end else begin
          state_d = neg_q ? S_MINUS : S_DIGIT;
        end
      end
      S_COMMA: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: CH_COMMA, last: 1'b0};
          if (kind_q == KIND_INT) state_d = neg_q ? S_MINUS : S_DIGIT;
          else                    state_d = S_SEQ;
        end
      end
      S_MINUS: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: CH_MINUS, last: 1'b0};
          state_d     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: CH_ZERO + {4'd0, top_digit},
                          last: (dcnt_q == DigitLast)};
          bcd_d       = {bcd_q[BcdW-5:0], 4'd0};
          dcnt_d      = dcnt_q + 5'd1;
          if (dcnt_q == DigitLast) state_d = S_IDLE;
        end
      end
      S_SEQ: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: seq_byte(kind_q, byte_q, truth_q, idx_q),
                          last: (idx_q == len - 3'd1)};
          idx_d       = idx_q + 3'd1;
          if (idx_q == len - 3'd1) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= in_data_i.kind;
      byte_q  <= in_data_i.byte_value;
      truth_q <= in_data_i.truth;
      comma_q <= in_data_i.comma_before;
      neg_q   <= in_data_i.number[NumW-1];
    end
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    dcnt_q <= dcnt_d;
    idx_q  <= idx_d;
    out_q  <= out_d;
  end

endmodule
